// ----- sv/pidaw_pkg.sv -----
// pidaw_pkg: widths, register indexes, item codes and transfer structs for the pid step block
// no dependencies; used by every module of the block and by its checker
`default_nettype none

package pidaw_pkg;

  // time base of the elapsed-time input
  localparam int TICKS_PER_SECOND = 1000;
  localparam int TICKS_W = $clog2(TICKS_PER_SECOND + 1);

  // field widths
  localparam int ERR_W   = 16;
  localparam int RATE_W  = 32;
  localparam int MS_W    = 16;
  localparam int GAIN_W  = 16;
  localparam int CLAMP_W = 32;
  localparam int CMD_W   = 32;
  localparam int ACC_W   = 48;
  localparam int KIND_W  = 2;
  localparam int IFRAC   = 8;

  // serial multiplier: wide signed operand times narrow signed operand
  localparam int MUL_A_W = ACC_W;
  localparam int MUL_B_W = (TICKS_W + 1 > MS_W + 1) ? TICKS_W + 1 : MS_W + 1;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // serial divider: unsigned magnitudes
  localparam int DIV_D_W  = (MS_W > TICKS_W) ? MS_W : TICKS_W;
  localparam int DIVN_INC = ERR_W - 1 + MS_W + IFRAC;
  localparam int DIVN_RTE = ERR_W + TICKS_W;
  localparam int DIV_N_W  = (DIVN_INC > DIVN_RTE) ? DIVN_INC : DIVN_RTE;

  // derived widths inside the datapath
  localparam int QS_W    = DIV_N_W + 1;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int ACCS_W  = ACC_W + 1;
  localparam int ITERM_W = MUL_P_W - IFRAC;
  localparam int SUM_W   = ITERM_W + 1;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ITERM_MIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ITERM_MAX  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WINDUP_ON  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_MS     = 3'd6;

  // reset values of the registers
  localparam logic signed [CLAMP_W-1:0] ITERM_MIN_RST = 32'sh8000_0000;
  localparam logic signed [CLAMP_W-1:0] ITERM_MAX_RST = 32'sh7FFF_FFFF;
  localparam logic [MS_W-1:0]           GAP_MS_RST    = 16'd100;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_DERIVE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SUPPLIED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [ERR_W-1:0]  error_in;
    logic signed [RATE_W-1:0] rate_in;
    logic [MS_W-1:0]          elapsed_ms;
    logic                     not_valid;
  } item_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] command;
    logic                    computed;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/pidaw_mul.sv -----
// pidaw_mul: bit-serial signed shift-add multiplier, one bit of the narrow operand per cycle
// depends on pidaw_pkg for operand widths
`default_nettype none

module pidaw_mul (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [pidaw_pkg::MUL_A_W-1:0]  a,
  input  logic signed [pidaw_pkg::MUL_B_W-1:0]  b,
  output logic                                  done,
  output logic signed [pidaw_pkg::MUL_P_W-1:0]  p
);

  localparam int HI_W  = pidaw_pkg::MUL_A_W + 2;
  localparam int CNT_W = $clog2(pidaw_pkg::MUL_B_W);
  localparam int FULL_W = HI_W + pidaw_pkg::MUL_B_W;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(pidaw_pkg::MUL_B_W - 1);

  logic signed [pidaw_pkg::MUL_A_W-1:0] a_reg;
  logic signed [HI_W-1:0]               hi;
  logic signed [HI_W-1:0]               addend;
  logic signed [HI_W-1:0]               hi_sum;
  logic [pidaw_pkg::MUL_B_W-1:0]        lo;
  logic [CNT_W-1:0]                     cnt;
  logic                                 busy;
  logic [FULL_W-1:0]                    full;

  always_comb begin
    addend = lo[0] ? {{2{a_reg[pidaw_pkg::MUL_A_W-1]}}, a_reg} : '0;
    // top bit of the narrow operand carries negative weight
    if (cnt == LAST) begin
      hi_sum = hi - addend;
    end else begin
      hi_sum = hi + addend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_reg <= a;
        hi    <= '0;
        lo    <= b;
        cnt   <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        hi  <= {hi_sum[HI_W-1], hi_sum[HI_W-1:1]};
        lo  <= {hi_sum[0], lo[pidaw_pkg::MUL_B_W-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign full = {hi, lo};
  assign p    = full[pidaw_pkg::MUL_P_W-1:0];

endmodule

`default_nettype wire

// ----- sv/pidaw_div.sv -----
// pidaw_div: restoring unsigned divider, one quotient bit per cycle
// depends on pidaw_pkg for dividend and divisor widths
`default_nettype none

module pidaw_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [pidaw_pkg::DIV_N_W-1:0]  dividend,
  input  logic [pidaw_pkg::DIV_D_W-1:0]  divisor,
  output logic                           done,
  output logic [pidaw_pkg::DIV_N_W-1:0]  quotient
);

  localparam int NW    = pidaw_pkg::DIV_N_W;
  localparam int DW    = pidaw_pkg::DIV_D_W;
  localparam int CNT_W = $clog2(NW);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(NW - 1);

  logic [DW-1:0]    rem;
  logic [DW-1:0]    dvs;
  logic [NW-1:0]    qr;
  logic [DW:0]      rem_sh;
  logic [DW+1:0]    trial;
  logic             fits;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  always_comb begin
    rem_sh = {rem, qr[NW-1]};
    trial  = {1'b0, rem_sh} - {2'b00, dvs};
    fits   = !trial[DW+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        dvs  <= divisor;
        qr   <= dividend;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? trial[DW-1:0] : rem_sh[DW-1:0];
        qr  <= {qr[NW-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = qr;

endmodule

`default_nettype wire

// ----- sv/pid_step_with_antiwindup.sv -----
// pid_step_with_antiwindup: fixed-point pid step with integral clamp, top level and sequencer
// depends on pidaw_pkg, pidaw_mul and pidaw_div
//
// usage
// - item channel (item_valid / item_stall / item): one error sample per transfer, with its
//   kind (derive rate, supplied rate, clear state), elapsed milliseconds and invalid flag
// - result channel (result_valid / result_stall / result): exactly one result per item,
//   command in Q16.16 saturated to 32 bits and a flag that says whether the step ran
// - cfg_we / cfg_index / cfg_data: register writes, taken at any edge with cfg_we high;
//   write only while no item is in flight
// - one item at a time: item_stall is high from the transfer until the result has moved
//   into the output register
// - time from item transfer to result valid is shortest for a forced-zero result or a clear,
//   longer for a full step without derived rate, and longest when the rate is
//   derived from the previous sample
// - the step time is set by the shared bit-serial multiplier (five products at most)
//   and the restoring divider (two quotients at most)
// - a result waiting in the output register does not block the next item: the next item is
//   taken and worked on, and only its final write waits while result_stall is high
// - reset (rst, synchronous) restores all registers to their reset values and clears the
//   controller history, integral and last rate; no result is pending after reset
`default_nettype none

module pid_step_with_antiwindup (
  input  logic                                 clk,
  input  logic                                 rst,
  // item channel
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  pidaw_pkg::item_t                     item,
  // result channel
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output pidaw_pkg::result_t                   result,
  // configuration
  input  logic                                 cfg_we,
  input  logic [pidaw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pidaw_pkg::CFG_DATA_W-1:0]     cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RATE_MUL,
    S_RATE_DIV,
    S_INC_MUL,
    S_INC_DIV,
    S_ACC,
    S_P_MUL,
    S_I_MUL,
    S_I_ADD,
    S_D_MUL,
    S_FINISH
  } state_t;

  state_t state;
  logic   go;          // start pulse for the unit of the state just entered

  // configuration registers
  logic signed [pidaw_pkg::GAIN_W-1:0]  prop_gain;
  logic signed [pidaw_pkg::GAIN_W-1:0]  integ_gain;
  logic signed [pidaw_pkg::GAIN_W-1:0]  deriv_gain;
  logic signed [pidaw_pkg::CLAMP_W-1:0] integ_term_min;
  logic signed [pidaw_pkg::CLAMP_W-1:0] integ_term_max;
  logic                                 windup_limit_on;
  logic [pidaw_pkg::MS_W-1:0]           deriv_gap_ms;

  // controller state
  logic signed [pidaw_pkg::ERR_W-1:0]   prev_error;
  logic                                 prev_valid;
  logic signed [pidaw_pkg::ACC_W-1:0]   integ_accum;
  logic signed [pidaw_pkg::RATE_W-1:0]  last_rate;

  // working registers of one step
  pidaw_pkg::item_t                     lat;
  logic signed [pidaw_pkg::DIFF_W-1:0]  diff;
  logic signed [pidaw_pkg::RATE_W-1:0]  rate;
  logic                                 neg;
  logic signed [pidaw_pkg::QS_W-1:0]    inc;
  logic signed [pidaw_pkg::ITERM_W-1:0] iterm;
  logic signed [pidaw_pkg::SUM_W-1:0]   sum;
  logic                                 computed;

  // unit connections
  logic                                 mul_start;
  logic                                 mul_done;
  logic signed [pidaw_pkg::MUL_A_W-1:0] mul_a;
  logic signed [pidaw_pkg::MUL_B_W-1:0] mul_b;
  logic signed [pidaw_pkg::MUL_P_W-1:0] mul_p;
  logic [pidaw_pkg::MUL_P_W-1:0]        mul_abs;
  logic                                 div_start;
  logic                                 div_done;
  logic [pidaw_pkg::DIV_N_W-1:0]        div_n;
  logic [pidaw_pkg::DIV_D_W-1:0]        div_d;
  logic [pidaw_pkg::DIV_N_W-1:0]        div_q;

  // combinational helpers
  logic                                 gap;
  logic signed [pidaw_pkg::QS_W-1:0]    quot_s;
  logic [pidaw_pkg::QS_W-pidaw_pkg::RATE_W:0] rate_hi;
  logic signed [pidaw_pkg::RATE_W-1:0]  rate_sat;
  logic signed [pidaw_pkg::ACCS_W-1:0]  acc_sum;
  logic signed [pidaw_pkg::ACC_W-1:0]   acc_sat;
  logic signed [pidaw_pkg::ITERM_W-1:0] it_lo;
  logic signed [pidaw_pkg::ITERM_W-1:0] it_cl;
  logic signed [pidaw_pkg::ITERM_W-1:0] it_sel;
  logic [pidaw_pkg::SUM_W-pidaw_pkg::CMD_W:0] sum_hi;
  logic signed [pidaw_pkg::CMD_W-1:0]   cmd_sat;

  localparam logic signed [pidaw_pkg::RATE_W-1:0] RATE_MAX =
    {1'b0, {(pidaw_pkg::RATE_W-1){1'b1}}};
  localparam logic signed [pidaw_pkg::RATE_W-1:0] RATE_MIN =
    {1'b1, {(pidaw_pkg::RATE_W-1){1'b0}}};
  localparam logic signed [pidaw_pkg::ACC_W-1:0] ACC_MAX =
    {1'b0, {(pidaw_pkg::ACC_W-1){1'b1}}};
  localparam logic signed [pidaw_pkg::ACC_W-1:0] ACC_MIN =
    {1'b1, {(pidaw_pkg::ACC_W-1){1'b0}}};
  localparam logic signed [pidaw_pkg::CMD_W-1:0] CMD_MAX =
    {1'b0, {(pidaw_pkg::CMD_W-1){1'b1}}};
  localparam logic signed [pidaw_pkg::CMD_W-1:0] CMD_MIN =
    {1'b1, {(pidaw_pkg::CMD_W-1){1'b0}}};

  // shared serial units
  pidaw_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  pidaw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  assign item_stall = (state != S_IDLE);

  assign mul_start = go && (state == S_RATE_MUL || state == S_INC_MUL || state == S_P_MUL ||
                            state == S_I_MUL || state == S_D_MUL);
  assign div_start = go && (state == S_RATE_DIV || state == S_INC_DIV);

  // magnitude of the last product, fed to the divider
  assign mul_abs = mul_p[pidaw_pkg::MUL_P_W-1] ? pidaw_pkg::MUL_P_W'(-mul_p)
                                                : pidaw_pkg::MUL_P_W'(mul_p);

  // operand selection per state
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_n = '0;
    div_d = '0;
    case (state)
      S_RATE_MUL: begin
        // error difference times ticks per second
        mul_a = pidaw_pkg::MUL_A_W'(diff);
        mul_b = pidaw_pkg::MUL_B_W'(pidaw_pkg::TICKS_PER_SECOND);
      end
      S_RATE_DIV: begin
        div_n = pidaw_pkg::DIV_N_W'(mul_abs);
        div_d = pidaw_pkg::DIV_D_W'(lat.elapsed_ms);
      end
      S_INC_MUL: begin
        // error times elapsed ms, scaled up by 256 before the divide
        mul_a = pidaw_pkg::MUL_A_W'(lat.error_in);
        mul_b = pidaw_pkg::MUL_B_W'(lat.elapsed_ms);
      end
      S_INC_DIV: begin
        div_n = pidaw_pkg::DIV_N_W'(mul_abs << pidaw_pkg::IFRAC);
        div_d = pidaw_pkg::DIV_D_W'(pidaw_pkg::TICKS_PER_SECOND);
      end
      S_P_MUL: begin
        mul_a = pidaw_pkg::MUL_A_W'(lat.error_in);
        mul_b = pidaw_pkg::MUL_B_W'(prop_gain);
      end
      S_I_MUL: begin
        mul_a = pidaw_pkg::MUL_A_W'(integ_accum);
        mul_b = pidaw_pkg::MUL_B_W'(integ_gain);
      end
      S_D_MUL: begin
        mul_a = pidaw_pkg::MUL_A_W'(rate);
        mul_b = pidaw_pkg::MUL_B_W'(deriv_gain);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // history is dropped when the gap exceeds the limit
  assign gap = (lat.elapsed_ms > deriv_gap_ms);

  // signed quotient, truncated toward zero
  assign quot_s = neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

  // derived rate saturated to 32 bits
  always_comb begin
    rate_hi = quot_s[pidaw_pkg::QS_W-1:pidaw_pkg::RATE_W-1];
    if ((&rate_hi) || !(|rate_hi)) begin
      rate_sat = quot_s[pidaw_pkg::RATE_W-1:0];
    end else begin
      rate_sat = quot_s[pidaw_pkg::QS_W-1] ? RATE_MIN : RATE_MAX;
    end
  end

  // integral update with 48-bit saturation
  always_comb begin
    acc_sum = pidaw_pkg::ACCS_W'(integ_accum) + pidaw_pkg::ACCS_W'(inc);
    if (acc_sum[pidaw_pkg::ACCS_W-1] != acc_sum[pidaw_pkg::ACCS_W-2]) begin
      acc_sat = acc_sum[pidaw_pkg::ACCS_W-1] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_sat = acc_sum[pidaw_pkg::ACC_W-1:0];
    end
  end

  // integral term clamp: raised to min first, then lowered to max, so max wins
  always_comb begin
    it_lo = (iterm < pidaw_pkg::ITERM_W'(integ_term_min)) ?
            pidaw_pkg::ITERM_W'(integ_term_min) : iterm;
    it_cl = (it_lo > pidaw_pkg::ITERM_W'(integ_term_max)) ?
            pidaw_pkg::ITERM_W'(integ_term_max) : it_lo;
    it_sel = windup_limit_on ? it_cl : iterm;
  end

  // command saturation to Q16.16
  always_comb begin
    sum_hi = sum[pidaw_pkg::SUM_W-1:pidaw_pkg::CMD_W-1];
    if ((&sum_hi) || !(|sum_hi)) begin
      cmd_sat = sum[pidaw_pkg::CMD_W-1:0];
    end else begin
      cmd_sat = sum[pidaw_pkg::SUM_W-1] ? CMD_MIN : CMD_MAX;
    end
  end

  // sequencer, registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      go              <= 1'b0;
      result_valid    <= 1'b0;
      prop_gain       <= '0;
      integ_gain      <= '0;
      deriv_gain      <= '0;
      integ_term_min  <= pidaw_pkg::ITERM_MIN_RST;
      integ_term_max  <= pidaw_pkg::ITERM_MAX_RST;
      windup_limit_on <= 1'b1;
      deriv_gap_ms    <= pidaw_pkg::GAP_MS_RST;
      prev_error      <= '0;
      prev_valid      <= 1'b0;
      integ_accum     <= '0;
      last_rate       <= '0;
    end else begin
      go <= 1'b0;

      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      // register writes
      if (cfg_we) begin
        case (cfg_index)
          pidaw_pkg::REG_PROP_GAIN:  prop_gain       <= cfg_data[pidaw_pkg::GAIN_W-1:0];
          pidaw_pkg::REG_INTEG_GAIN: integ_gain      <= cfg_data[pidaw_pkg::GAIN_W-1:0];
          pidaw_pkg::REG_DERIV_GAIN: deriv_gain      <= cfg_data[pidaw_pkg::GAIN_W-1:0];
          pidaw_pkg::REG_ITERM_MIN:  integ_term_min  <= cfg_data[pidaw_pkg::CLAMP_W-1:0];
          pidaw_pkg::REG_ITERM_MAX:  integ_term_max  <= cfg_data[pidaw_pkg::CLAMP_W-1:0];
          pidaw_pkg::REG_WINDUP_ON:  windup_limit_on <= cfg_data[0];
          pidaw_pkg::REG_GAP_MS:     deriv_gap_ms    <= cfg_data[pidaw_pkg::MS_W-1:0];
          default: begin
          end
        endcase
      end

      case (state)
        S_IDLE: begin
          if (item_valid) begin
            lat   <= item;
            state <= S_DECODE;
          end
        end

        S_DECODE: begin
          // default: forced-zero result
          sum      <= '0;
          computed <= 1'b0;
          state    <= S_FINISH;
          case (lat.kind)
            pidaw_pkg::KIND_DERIVE: begin
              if (lat.error_in != '0 && lat.elapsed_ms != '0 && !lat.not_valid) begin
                computed   <= 1'b1;
                diff       <= pidaw_pkg::DIFF_W'(lat.error_in) -
                              pidaw_pkg::DIFF_W'(prev_error);
                prev_error <= lat.error_in;
                prev_valid <= 1'b1;
                go         <= 1'b1;
                if (prev_valid && !gap) begin
                  state <= S_RATE_MUL;
                end else begin
                  // no usable history: keep the last rate unless the gap dropped it
                  rate      <= gap ? '0 : last_rate;
                  last_rate <= gap ? '0 : last_rate;
                  state     <= S_INC_MUL;
                end
              end
            end
            pidaw_pkg::KIND_SUPPLIED: begin
              if (!lat.not_valid) begin
                last_rate <= lat.rate_in;
              end
              if (lat.elapsed_ms != '0 && !lat.not_valid) begin
                computed <= 1'b1;
                rate     <= lat.rate_in;
                go       <= 1'b1;
                state    <= S_INC_MUL;
              end
            end
            pidaw_pkg::KIND_CLEAR: begin
              prev_error  <= '0;
              prev_valid  <= 1'b0;
              integ_accum <= '0;
              last_rate   <= '0;
            end
            default: begin
            end
          endcase
        end

        S_RATE_MUL: begin
          if (mul_done) begin
            neg   <= mul_p[pidaw_pkg::MUL_P_W-1];
            go    <= 1'b1;
            state <= S_RATE_DIV;
          end
        end

        S_RATE_DIV: begin
          if (div_done) begin
            rate      <= rate_sat;
            last_rate <= rate_sat;
            go        <= 1'b1;
            state     <= S_INC_MUL;
          end
        end

        S_INC_MUL: begin
          if (mul_done) begin
            neg   <= mul_p[pidaw_pkg::MUL_P_W-1];
            go    <= 1'b1;
            state <= S_INC_DIV;
          end
        end

        S_INC_DIV: begin
          if (div_done) begin
            inc   <= quot_s;
            state <= S_ACC;
          end
        end

        S_ACC: begin
          integ_accum <= acc_sat;
          go          <= 1'b1;
          state       <= S_P_MUL;
        end

        S_P_MUL: begin
          if (mul_done) begin
            sum   <= mul_p[pidaw_pkg::SUM_W-1:0];
            go    <= 1'b1;
            state <= S_I_MUL;
          end
        end

        S_I_MUL: begin
          if (mul_done) begin
            // floor of the product over 256
            iterm <= mul_p[pidaw_pkg::MUL_P_W-1:pidaw_pkg::IFRAC];
            state <= S_I_ADD;
          end
        end

        S_I_ADD: begin
          sum   <= sum + pidaw_pkg::SUM_W'(it_sel);
          go    <= 1'b1;
          state <= S_D_MUL;
        end

        S_D_MUL: begin
          if (mul_done) begin
            sum   <= sum + mul_p[pidaw_pkg::SUM_W-1:0];
            state <= S_FINISH;
          end
        end

        S_FINISH: begin
          // hold here while an earlier result still waits to be taken
          if (!result_valid || !result_stall) begin
            result.command  <= cmd_sat;
            result.computed <= computed;
            result_valid    <= 1'b1;
            state           <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/pidaw_chk.sv -----
// pidaw_chk: port-level checks of the pid step block, attached to the top level by bind
// depends on pidaw_pkg and on pid_step_with_antiwindup
`default_nettype none

module pidaw_chk (
  input logic                             clk,
  input logic                             rst,
  input logic                             item_valid,
  input logic                             item_stall,
  input logic                             result_valid,
  input logic                             result_stall,
  input pidaw_pkg::result_t               result,
  input logic                             cfg_we
);

  // a stalled result stays and keeps its payload
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // one item at a time: a transfer closes the item channel in the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("item channel open right after a transfer");

  // a forced-zero result carries a zero command
  a_zero_when_skipped: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.computed || result.command == '0))
    else $error("nonzero command on a skipped step");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // register writes must come only while the block is empty; the block does not enforce it
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_we |-> !item_stall && !result_valid)
    else $error("register write with an item in flight");

endmodule

bind pid_step_with_antiwindup pidaw_chk u_pidaw_chk (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result),
  .cfg_we       (cfg_we)
);

`default_nettype wire
